>>> sv/rfe_pkg.sv
// ----------------------------------------------------------------------------
// Tile rotate/flip engine package
// Shared widths, codes and types of the tile rotate/flip engine.
// ----------------------------------------------------------------------------
package rfe_pkg;

  localparam int PIX_W        = 8;
  localparam int SIDE_W       = 5;
  localparam int MODE_W       = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int DEF_MAX_SIDE = 16;
  localparam int SIDE_LIMIT   = (2 ** SIDE_W) - 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [SIDE_W-1:0] ROWS_RESET = SIDE_W'(16);
  localparam logic [SIDE_W-1:0] COLS_RESET = SIDE_W'(16);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 2'd2;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDENT  = 3'd0,
    MODE_ROT90  = 3'd1,
    MODE_ROT180 = 3'd2,
    MODE_ROT270 = 3'd3,
    MODE_FLIP_H = 3'd4,
    MODE_FLIP_V = 3'd5,
    MODE_NEGATE = 3'd6
  } mode_t;

  typedef enum logic {
    FS_RUN  = 1'b0,
    FS_SYNC = 1'b1
  } front_state_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last;
    logic             shape_error;
  } out_item_t;

  // Effective (clamped) tile configuration.
  typedef struct packed {
    logic [SIDE_W-1:0] rows;
    logic [SIDE_W-1:0] cols;
    mode_t             mode;
  } tile_cfg_t;

  // One classified output request: source row and column in the store.
  typedef struct packed {
    logic [SIDE_W-1:0] src_row;
    logic [SIDE_W-1:0] src_col;
    logic              last;
    logic              err;
    logic              neg;
  } q_entry_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

>>> sv/rfe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
module rfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/rfe_queue.sv
// ----------------------------------------------------------------------------
// Request queue
// Short FIFO of classified output requests between front and back.
// ----------------------------------------------------------------------------
module rfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfe_pkg::q_entry_t push_entry,
  input  logic              pop,
  output rfe_pkg::q_entry_t head,
  output rfe_pkg::q_status_t status
);

  import rfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign do_pop           = pop && (count != '0);
  assign head             = entries[rd_ptr];
  assign status.full      = (count == CNT_W'(QUEUE_DEPTH));
  assign status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> sv/rfe_front.sv
// ----------------------------------------------------------------------------
// Tile engine front
// Accepts requests, writes loads into the store, tracks the output position
// and classifies output requests into store coordinates for the back.
// ----------------------------------------------------------------------------
module rfe_front #(
  parameter int MAX_SIDE = rfe_pkg::DEF_MAX_SIDE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  rfe_pkg::in_item_t                      req,
  output logic                                   busy,
  input  rfe_pkg::tile_cfg_t                     cfg,
  input  logic                                   size_write,
  input  rfe_pkg::q_status_t                     q_status,
  output logic                                   q_push,
  output rfe_pkg::q_entry_t                      q_entry,
  output logic                                   ram_we,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   ram_addr,
  output logic [rfe_pkg::PIX_W-1:0]              ram_data
);

  import rfe_pkg::*;

  localparam int SIDE_MAX = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
  localparam int AW       = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CW       = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int DCW      = $clog2(CW + 1);

  front_state_t      state;
  front_state_t      state_next;
  logic [CW-1:0]     load_count;
  logic [CW-1:0]     emit_count;
  logic [SIDE_W-1:0] row_cnt;
  logic [SIDE_W-1:0] col_cnt;
  logic [CW-1:0]     div_quo;
  logic [SIDE_W-1:0] div_rem;
  logic [DCW-1:0]    div_cnt;

  logic                  sync_done;
  logic                  div_step;
  logic                  accept;
  logic [2*SIDE_W-1:0]   total_prod;
  logic [CW-1:0]         total;
  logic                  tile_full;
  logic                  is_last;
  logic [SIDE_W-1:0]     pos_row;
  logic [SIDE_W-1:0]     pos_col;
  logic [SIDE_W:0]       div_shift;
  logic [SIDE_W+1:0]     div_diff;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FS_RUN: begin
        if (size_write) state_next = FS_SYNC;
      end
      FS_SYNC: begin
        if (!size_write && div_cnt == '0) state_next = FS_RUN;
      end
      default: state_next = FS_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    busy      = 1'b0;
    sync_done = 1'b0;
    div_step  = 1'b0;
    case (state)
      FS_RUN: begin
        busy = q_status.full;
      end
      FS_SYNC: begin
        busy      = 1'b1;
        sync_done = !size_write && (div_cnt == '0);
        div_step  = !size_write && (div_cnt != '0);
      end
      default: busy = 1'b1;
    endcase
  end

  assign accept     = start && !busy;
  assign total_prod = {{SIDE_W{1'b0}}, cfg.rows} * {{SIDE_W{1'b0}}, cfg.cols};
  assign total      = CW'(total_prod);
  assign tile_full  = (load_count >= total);
  assign is_last    = (emit_count >= total - 1'b1);
  assign pos_row    = is_last ? cfg.rows - 1'b1 : row_cnt;
  assign pos_col    = is_last ? cfg.cols - 1'b1 : col_cnt;

  assign ram_we   = accept && (req.kind == KIND_LOAD) && !tile_full;
  assign ram_addr = AW'(load_count);
  assign ram_data = req.pixel_in;
  assign q_push   = accept && (req.kind == KIND_EMIT) && tile_full;

  // Map the output position to its source position in the store.
  always_comb begin
    q_entry.src_row = pos_row;
    q_entry.src_col = pos_col;
    q_entry.last    = is_last;
    q_entry.err     = 1'b0;
    q_entry.neg     = 1'b0;
    case (cfg.mode)
      MODE_ROT90: begin
        q_entry.err     = (cfg.rows != cfg.cols);
        q_entry.src_row = pos_col;
        q_entry.src_col = cfg.rows - 1'b1 - pos_row;
      end
      MODE_ROT180: begin
        q_entry.src_row = cfg.rows - 1'b1 - pos_row;
        q_entry.src_col = cfg.cols - 1'b1 - pos_col;
      end
      MODE_ROT270: begin
        q_entry.err     = (cfg.rows != cfg.cols);
        q_entry.src_row = cfg.rows - 1'b1 - pos_col;
        q_entry.src_col = pos_row;
      end
      MODE_FLIP_H: begin
        q_entry.src_col = cfg.cols - 1'b1 - pos_col;
      end
      MODE_FLIP_V: begin
        q_entry.src_row = cfg.rows - 1'b1 - pos_row;
      end
      MODE_NEGATE: begin
        q_entry.neg = 1'b1;
      end
      default: begin
        q_entry.neg = 1'b0;
      end
    endcase
  end

  // One restoring division step: emit_count / cols gives row and column.
  assign div_shift = {div_rem, div_quo[CW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, cfg.cols};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FS_RUN;
      load_count <= '0;
      emit_count <= '0;
      row_cnt    <= '0;
      col_cnt    <= '0;
      div_cnt    <= '0;
    end else begin
      state <= state_next;
      if (size_write) begin
        div_cnt <= DCW'(CW);
      end else if (div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (sync_done) begin
        row_cnt <= SIDE_W'(div_quo);
        col_cnt <= div_rem;
      end else if (ram_we) begin
        load_count <= load_count + 1'b1;
      end else if (q_push) begin
        if (is_last) begin
          load_count <= '0;
          emit_count <= '0;
          row_cnt    <= '0;
          col_cnt    <= '0;
        end else begin
          emit_count <= emit_count + 1'b1;
          if (col_cnt + 1'b1 == cfg.cols) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (size_write) begin
      div_quo <= emit_count;
      div_rem <= '0;
    end else if (div_step) begin
      if (!div_diff[SIDE_W+1]) begin
        div_rem <= div_diff[SIDE_W-1:0];
        div_quo <= {div_quo[CW-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[SIDE_W-1:0];
        div_quo <= {div_quo[CW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/rfe_back.sv
// ----------------------------------------------------------------------------
// Tile engine back
// Turns queued source coordinates into a store address, reads the byte and
// registers the finished result.
// ----------------------------------------------------------------------------
module rfe_back #(
  parameter int MAX_SIDE = rfe_pkg::DEF_MAX_SIDE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rfe_pkg::q_status_t                   q_status,
  input  rfe_pkg::q_entry_t                    q_head,
  output logic                                 q_pop,
  input  logic [rfe_pkg::SIDE_W-1:0]           cols,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] ram_addr,
  input  logic [rfe_pkg::PIX_W-1:0]            ram_data,
  output rfe_pkg::out_item_t                   result,
  output logic                                 result_valid
);

  import rfe_pkg::*;

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  logic [2*SIDE_W-1:0] row_base;
  logic [2*SIDE_W:0]   addr_sum;
  logic                rd_valid;
  logic                rd_last;
  logic                rd_err;
  logic                rd_neg;

  // The back never stalls: a queued request is taken as soon as it is there.
  assign q_pop    = q_status.not_empty;
  assign row_base = {{SIDE_W{1'b0}}, q_head.src_row} * {{SIDE_W{1'b0}}, cols};
  assign addr_sum = {1'b0, row_base} + {{(SIDE_W+1){1'b0}}, q_head.src_col};
  assign ram_addr = AW'(addr_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid     <= q_pop;
      result_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= q_head.last;
    rd_err  <= q_head.err;
    rd_neg  <= q_head.neg;
    result.last        <= rd_last;
    result.shape_error <= rd_err;
    if (rd_err) begin
      result.pixel_out <= '0;
    end else if (rd_neg) begin
      result.pixel_out <= ~ram_data;
    end else begin
      result.pixel_out <= ram_data;
    end
  end

endmodule

>>> sv/tile_rotate_flip_engine_core.sv
// ----------------------------------------------------------------------------
// Tile rotate/flip engine core
// An accepted output request passes the queue, the store read and the result
// register; its result stays on the result ports for one cycle, and the
// receiver cannot stall. One request per cycle is taken while busy is low; a
// write to tile_rows or tile_cols holds busy while the position divider runs.
// Reset clears the counters, the queue and the registers to their defaults;
// the tile store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module tile_rotate_flip_engine_core #(
  parameter int MAX_SIDE = rfe_pkg::DEF_MAX_SIDE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  rfe_pkg::in_item_t                req,
  output logic                             busy,
  output rfe_pkg::out_item_t               result,
  output logic                             result_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import rfe_pkg::*;

  // Sides are clamped to what the 5-bit registers and the store can hold.
  localparam int SIDE_MAX = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = $clog2(DEPTH);

  logic [SIDE_W-1:0] tile_rows;
  logic [SIDE_W-1:0] tile_cols;
  mode_t             transform_mode;

  tile_cfg_t   cfg_eff;
  logic        cfg_write;
  logic        size_write;
  q_status_t   q_status;
  logic        q_push;
  logic        q_pop;
  q_entry_t    q_push_entry;
  q_entry_t    q_head;
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [PIX_W-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [PIX_W-1:0] ram_rd_data;

  // The configuration port is always ready. A write to a size register
  // restarts the divider that re-derives the current row and column from
  // the linear output count, since the column count defines that split.
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign size_write = cfg_write && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_rows      <= ROWS_RESET;
      tile_cols      <= COLS_RESET;
      transform_mode <= MODE_IDENT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROWS: tile_rows      <= cfg_data[SIDE_W-1:0];
        CFG_COLS: tile_cols      <= cfg_data[SIDE_W-1:0];
        CFG_MODE: transform_mode <= mode_t'(cfg_data[MODE_W-1:0]);
        default:  tile_rows      <= tile_rows;
      endcase
    end
  end

  // A side of zero acts as one, and a side above the limit acts as the limit.
  always_comb begin
    if (tile_rows == '0) begin
      cfg_eff.rows = SIDE_W'(1);
    end else if (tile_rows > SIDE_W'(SIDE_MAX)) begin
      cfg_eff.rows = SIDE_W'(SIDE_MAX);
    end else begin
      cfg_eff.rows = tile_rows;
    end
    if (tile_cols == '0) begin
      cfg_eff.cols = SIDE_W'(1);
    end else if (tile_cols > SIDE_W'(SIDE_MAX)) begin
      cfg_eff.cols = SIDE_W'(SIDE_MAX);
    end else begin
      cfg_eff.cols = tile_cols;
    end
    cfg_eff.mode = transform_mode;
  end

  // The front writes loads straight into the store and queues each output
  // request on a full tile as a source coordinate with its last, error and negate flags.
  rfe_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .cfg        (cfg_eff),
    .size_write (size_write),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_entry    (q_push_entry),
    .ram_we     (ram_we),
    .ram_addr   (ram_wr_addr),
    .ram_data   (ram_wr_data)
  );

  rfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // The tile store. Reads return old data on a same-address write, so the
  // first load of a new tile cannot disturb the final read of the old one.
  rfe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The back computes the store address, reads it and registers the result.
  rfe_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .cols         (cfg_eff.cols),
    .ram_addr     (ram_rd_addr),
    .ram_data     (ram_rd_data),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef ASSERT_OFF
  // A shape error only comes from a quarter turn and always carries zero data.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.shape_error |->
      result.pixel_out == '0 &&
      (transform_mode == MODE_ROT90 || transform_mode == MODE_ROT270))
    else $error("shape error outside a quarter turn or with nonzero data");

  // A load never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.kind == KIND_LOAD |-> ##3 !result_valid)
    else $error("result produced by a load request");

  // Every result traces back to an accepted output request.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && req.kind == KIND_EMIT, 3))
    else $error("result without a matching output request");
`endif

endmodule

>>> tb/tile_rotate_flip_engine_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile rotate/flip engine checker
// Watches the request, result and register channels of the engine, keeps its
// own copy of the tile and the registers, and compares every result with the
// oldest predicted pixel.
// ----------------------------------------------------------------------------
module tile_rotate_flip_engine_core_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  rfe_pkg::in_item_t                req,
  input  logic                             busy,
  input  rfe_pkg::out_item_t               result,
  input  logic                             result_valid,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               open_requests
);
  import rfe_pkg::*;

  localparam int TILE_BYTES = DEF_MAX_SIDE * DEF_MAX_SIDE;

  logic [PIX_W-1:0]  tile_copy [0:TILE_BYTES-1];
  int                loaded_bytes;
  int                emitted_bytes;
  logic [SIDE_W-1:0] rows_reg;
  logic [SIDE_W-1:0] cols_reg;
  logic [MODE_W-1:0] mode_reg;
  out_item_t         expected_pixels [$];

  // Sizes of zero act as one, sizes above the maximum side act as the maximum.
  function automatic int clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
    return int'(v);
  endfunction

  task automatic transform_request(input in_item_t item);
    int               nr;
    int               nc;
    int               total;
    int               pos;
    int               r;
    int               c;
    int               a;
    int               b;
    logic             err;
    logic             fin;
    logic [PIX_W-1:0] pix;
    out_item_t        want;
    nr    = clamp_side(rows_reg);
    nc    = clamp_side(cols_reg);
    total = nr * nc;
    if (item.kind == KIND_LOAD) begin
      if (loaded_bytes < total) begin
        tile_copy[loaded_bytes] = item.pixel_in;
        loaded_bytes++;
      end
    end else if (loaded_bytes >= total) begin
      // A shrunk tile pins the position at the final byte.
      pos = emitted_bytes;
      fin = 1'b0;
      if (pos >= total - 1) begin
        pos = total - 1;
        fin = 1'b1;
      end
      r   = pos / nc;
      c   = pos % nc;
      a   = r;
      b   = c;
      err = 1'b0;
      case (mode_reg)
        MODE_ROT90: begin
          if (nr != nc) err = 1'b1;
          else begin
            a = c;
            b = nr - 1 - r;
          end
        end
        MODE_ROT180: begin
          a = nr - 1 - r;
          b = nc - 1 - c;
        end
        MODE_ROT270: begin
          if (nr != nc) err = 1'b1;
          else begin
            a = nr - 1 - c;
            b = r;
          end
        end
        MODE_FLIP_H: b = nc - 1 - c;
        MODE_FLIP_V: a = nr - 1 - r;
        default: ;
      endcase
      pix = err ? '0 : tile_copy[a * nc + b];
      if (mode_reg == MODE_NEGATE) pix = ~pix;
      if (fin) begin
        loaded_bytes  = 0;
        emitted_bytes = 0;
      end else begin
        emitted_bytes++;
      end
      want.pixel_out   = pix;
      want.last        = fin;
      want.shape_error = err;
      expected_pixels.push_back(want);
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %02h last=%0b err=%0b",
               $time, got.pixel_out, got.last, got.shape_error);
      fail_count++;
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out mismatch: expected %02h, actual %02h",
                 $time, want.pixel_out, got.pixel_out);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
        fail_count++;
      end
      if (got.shape_error !== want.shape_error) begin
        $display("%0t: shape_error mismatch: expected %0b, actual %0b",
                 $time, want.shape_error, got.shape_error);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loaded_bytes  = 0;
      emitted_bytes = 0;
      rows_reg      = ROWS_RESET;
      cols_reg      = COLS_RESET;
      mode_reg      = MODE_IDENT;
      expected_pixels.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_ROWS: rows_reg = cfg_data;
          CFG_COLS: cols_reg = cfg_data;
          CFG_MODE: mode_reg = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) transform_request(req);
      if (result_valid === 1'b1) check_pixel(result);
    end
    open_requests <= expected_pixels.size();
  end

endmodule

>>> tb/tile_rotate_flip_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile rotate/flip engine core testbench
// Drives load and emit requests in bursts and register writes between phases,
// while a checker beside the engine predicts every pixel and counts failures.
// ----------------------------------------------------------------------------
module tile_rotate_flip_engine_core_tb;
  import rfe_pkg::*;

  // The random part stops once this many well-formed requests have gone out.
  localparam int SHAPED_TARGET = 900;
  // Cycles allowed after the last expected pixel for loads still in flight.
  localparam int SETTLE_CYCLES = 8;
  // Hard stop, far above the slowest correct run.
  localparam int CYCLE_LIMIT   = 300000;

  // Register index that selects no register, and the mode code left unused.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]      MODE_SPARE = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  in_item_t               req;
  logic                   busy;
  out_item_t              result;
  logic                   result_valid;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int                     fail_count;
  int                     open_requests;
  int                     cycle_count = 0;
  int                     shaped_items;
  int                     burst_left;

  // Shadows of the size registers, used only to shape request sequences.
  logic [SIDE_W-1:0]      rows_now;
  logic [SIDE_W-1:0]      cols_now;

  tile_rotate_flip_engine_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tile_rotate_flip_engine_core_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req           (req),
    .busy          (busy),
    .result        (result),
    .result_valid  (result_valid),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .open_requests (open_requests)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A hung handshake or a pixel that never comes ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
    return int'(v);
  endfunction

  // Mostly small sides keep tiles short; a few full-size and out-of-range
  // values reach the clamping logic.
  function automatic logic [SIDE_W-1:0] pick_side();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) return SIDE_W'($urandom_range(1, 5));
    if (roll < 91) return SIDE_W'($urandom_range(6, 15));
    if (roll < 95) return SIDE_W'(DEF_MAX_SIDE);
    if (roll < 97) return '0;
    return SIDE_W'($urandom_range(17, 31));
  endfunction

  // Presents one request at the falling edge and holds it until the engine
  // takes it. Start stays high into the next request unless a gap follows;
  // gaps come at the end of bursts of random length, so they land on every
  // phase of a tile. Some bursts run straight on into the next one.
  task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
    int gap;
    int roll;
    @(negedge clk);
    start        = 1'b1;
    req.kind     = kind;
    req.pixel_in = pix;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      roll       = $urandom_range(0, 9);
      if (roll < 3) gap = 0;
      else if (roll < 8) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 12);
      repeat (gap) begin
        @(negedge clk);
        start        = 1'b0;
        req.kind     = 1'($urandom);
        req.pixel_in = PIX_W'($urandom);
      end
    end
  endtask

  // Occasional stray request inside a well-formed sequence: early emits,
  // loads into a full tile, or emits that shift the read position.
  task automatic maybe_stray();
    if ($urandom_range(0, 11) == 0) send_item(1'($urandom), PIX_W'($urandom));
  endtask

  // Lets every expected pixel arrive, then a few more cycles for loads and
  // resultless emits still in the pipeline.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (open_requests != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_ROWS) rows_now = val[SIDE_W-1:0];
    if (idx == CFG_COLS) cols_now = val[SIDE_W-1:0];
  endtask

  // One phase: new register settings, then one to three tiles of loads and
  // emits. Now and then the emits stop early, so the next phase starts with a
  // half-read tile and possibly a smaller or larger size.
  task automatic random_phase();
    int nr;
    int nc;
    int total;
    int tiles;
    int emits;
    int k;
    int t;
    wait_drained();
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ROWS, pick_side());
    if ($urandom_range(0, 3) != 0) begin
      // Square tiles half the time so the quarter turns do real work.
      if ($urandom_range(0, 1) == 1) write_reg(CFG_COLS, rows_now);
      else write_reg(CFG_COLS, pick_side());
    end
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_MODE, {2'($urandom), MODE_W'($urandom_range(0, 7))});
    if ($urandom_range(0, 29) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    nr    = eff_side(rows_now);
    nc    = eff_side(cols_now);
    total = nr * nc;
    tiles = $urandom_range(1, 3);
    for (t = 0; t < tiles; t++) begin
      for (k = 0; k < total; k++) begin
        maybe_stray();
        send_item(KIND_LOAD, PIX_W'($urandom));
        shaped_items++;
      end
      if ($urandom_range(0, 9) == 0) send_item(KIND_LOAD, PIX_W'($urandom));
      emits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
      for (k = 0; k < emits; k++) begin
        maybe_stray();
        send_item(KIND_EMIT, PIX_W'($urandom));
        shaped_items++;
      end
      if (emits < total) break;
    end
  endtask

  initial begin
    int k;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROWS;
    cfg_data     = '0;
    rows_now     = ROWS_RESET;
    cols_now     = COLS_RESET;
    burst_left   = 1;
    shaped_items = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // An emit before anything is loaded returns nothing.
    send_item(KIND_EMIT, 8'hFF);
    wait_drained();

    // Quarter turn of a 2x2 tile holding the byte extremes; the fifth load
    // lands on a full tile and is dropped.
    write_reg(CFG_ROWS, 5'd2);
    write_reg(CFG_COLS, 5'd2);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ROT90));
    send_item(KIND_LOAD, 8'h00);
    send_item(KIND_LOAD, 8'hFF);
    send_item(KIND_LOAD, 8'hA5);
    send_item(KIND_LOAD, 8'h5A);
    send_item(KIND_LOAD, 8'h3C);
    for (k = 0; k < 4; k++) send_item(KIND_EMIT, 8'h00);
    wait_drained();

    // Three-quarter turn on a non-square tile: a zero row count acts as one,
    // so the 1x2 tile reports a shape error with zero data on both bytes.
    write_reg(CFG_ROWS, 5'd0);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ROT270));
    send_item(KIND_LOAD, 8'h81);
    send_item(KIND_LOAD, 8'h7E);
    send_item(KIND_EMIT, 8'hFF);
    send_item(KIND_EMIT, 8'h00);
    wait_drained();

    // Unused mode code acts as identity. Four of six bytes are read, then the
    // tile shrinks to 1x3, so the next emit jumps to the final byte.
    write_reg(CFG_ROWS, 5'd2);
    write_reg(CFG_COLS, 5'd3);
    write_reg(CFG_MODE, {2'b11, MODE_SPARE});
    for (k = 0; k < 6; k++) send_item(KIND_LOAD, PIX_W'(8'h10 + k));
    for (k = 0; k < 4; k++) send_item(KIND_EMIT, 8'h00);
    wait_drained();
    write_reg(CFG_ROWS, 5'd1);
    send_item(KIND_EMIT, 8'h00);

    while (shaped_items < SHAPED_TARGET) random_phase();

    wait_drained();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rfe_pkg.sv
sv/rfe_ram.sv
sv/rfe_queue.sv
sv/rfe_front.sv
sv/rfe_back.sv
sv/tile_rotate_flip_engine_core.sv
tb/tile_rotate_flip_engine_core_checker.sv
tb/tile_rotate_flip_engine_core_tb.sv
